>>> rtl/core/kvst_pkg.sv
`timescale 1ns / 1ps

package kvst_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] KEY_LIMIT   = 7'd64;
    localparam logic [COUNT_W-1:0] VALUE_LIMIT = 7'd64;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_QUOTE = 8'h22;

    localparam logic [CHAR_W-1:0] EQUAL_A_RESET = 8'd61;
    localparam logic [CHAR_W-1:0] SEP_A_RESET   = 8'd59;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EQUAL_A = 3'd0,
        REG_EQUAL_B = 3'd1,
        REG_EQUAL_C = 3'd2,
        REG_SEP_A   = 3'd3,
        REG_SEP_B   = 3'd4,
        REG_SEP_C   = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_KEY   = 3'd0,
        KIND_VALUE = 3'd1,
        KIND_MORE  = 3'd2,
        KIND_FINAL = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef struct packed {
        logic is_term;
        logic is_quote;
        logic is_equal;
        logic is_sep;
    } byte_class_t;

endpackage

>>> rtl/core/key_value_string_tokenizer_unit.sv
`timescale 1ns / 1ps

// Splits a byte stream into key and value characters, pair-end marks and error
// marks. One byte is taken every clock cycle while results are drained; a byte is
// held in an input register, classified combinationally and applied to the parse
// state when it steps, and its result (if any) is then registered in the output
// register. A new byte can enter the input register as the held byte is applied.
module key_value_string_tokenizer_unit
#(
    parameter logic [kvst_pkg::COUNT_W-1:0] KEY_LIMIT   = kvst_pkg::KEY_LIMIT,
    parameter logic [kvst_pkg::COUNT_W-1:0] VALUE_LIMIT = kvst_pkg::VALUE_LIMIT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kvst_pkg::CHAR_W-1:0]     s_axis_tdata,  // [7:0] in_byte
    input  logic                            s_axis_tuser,  // [0] first
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kvst_pkg::CHAR_W-1:0]     m_axis_tdata,  // [7:0] out_char
    output logic [2:0]                      m_axis_tuser,  // [2:0] kind
    input  logic                            cfg_we,
    input  logic [kvst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kvst_pkg::CHAR_W-1:0]     cfg_data
);

    logic                        in_valid_reg;
    logic [kvst_pkg::CHAR_W-1:0] in_byte_reg;
    logic                        in_first_reg;
    logic                        out_valid_reg;
    logic [kvst_pkg::CHAR_W-1:0] out_char_reg;
    kvst_pkg::kind_t             out_kind_reg;

    logic                        step;
    kvst_pkg::byte_class_t       byte_class;
    logic                        res_valid;
    kvst_pkg::kind_t             res_kind;
    logic [kvst_pkg::CHAR_W-1:0] res_char;

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    kvst_class u_class
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_byte    (in_byte_reg),
        .byte_class (byte_class)
    );

    kvst_parse
    #(
        .KEY_LIMIT   (KEY_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    )
    u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .first      (in_first_reg),
        .in_byte    (in_byte_reg),
        .byte_class (byte_class),
        .res_valid  (res_valid),
        .res_kind   (res_kind),
        .res_char   (res_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_char_reg <= res_char;
            out_kind_reg <= res_kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

>>> rtl/core/kvst_class.sv
`timescale 1ns / 1ps

module kvst_class
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [kvst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kvst_pkg::CHAR_W-1:0]     cfg_data,
    input  logic [kvst_pkg::CHAR_W-1:0]     in_byte,
    output kvst_pkg::byte_class_t           byte_class
);

    logic [kvst_pkg::CHAR_W-1:0] equal_a_reg;
    logic [kvst_pkg::CHAR_W-1:0] equal_b_reg;
    logic [kvst_pkg::CHAR_W-1:0] equal_c_reg;
    logic [kvst_pkg::CHAR_W-1:0] sep_a_reg;
    logic [kvst_pkg::CHAR_W-1:0] sep_b_reg;
    logic [kvst_pkg::CHAR_W-1:0] sep_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            equal_a_reg <= kvst_pkg::EQUAL_A_RESET;
            equal_b_reg <= '0;
            equal_c_reg <= '0;
            sep_a_reg   <= kvst_pkg::SEP_A_RESET;
            sep_b_reg   <= '0;
            sep_c_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kvst_pkg::REG_EQUAL_A: equal_a_reg <= cfg_data;
                kvst_pkg::REG_EQUAL_B: equal_b_reg <= cfg_data;
                kvst_pkg::REG_EQUAL_C: equal_c_reg <= cfg_data;
                kvst_pkg::REG_SEP_A:   sep_a_reg   <= cfg_data;
                kvst_pkg::REG_SEP_B:   sep_b_reg   <= cfg_data;
                kvst_pkg::REG_SEP_C:   sep_c_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        byte_class.is_term  = (in_byte == kvst_pkg::CHAR_NUL) ||
                              (in_byte == kvst_pkg::CHAR_LF)  ||
                              (in_byte == kvst_pkg::CHAR_CR);
        byte_class.is_quote = (in_byte == kvst_pkg::CHAR_QUOTE);
        byte_class.is_equal = (in_byte == equal_a_reg) || (in_byte == equal_b_reg) ||
                              (in_byte == equal_c_reg);
        byte_class.is_sep   = (in_byte == sep_a_reg) || (in_byte == sep_b_reg) ||
                              (in_byte == sep_c_reg);
    end

endmodule

>>> rtl/core/kvst_parse.sv
`timescale 1ns / 1ps

module kvst_parse
#(
    parameter logic [kvst_pkg::COUNT_W-1:0] KEY_LIMIT   = kvst_pkg::KEY_LIMIT,
    parameter logic [kvst_pkg::COUNT_W-1:0] VALUE_LIMIT = kvst_pkg::VALUE_LIMIT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         first,
    input  logic [kvst_pkg::CHAR_W-1:0]  in_byte,
    input  kvst_pkg::byte_class_t        byte_class,
    output logic                         res_valid,
    output kvst_pkg::kind_t              res_kind,
    output logic [kvst_pkg::CHAR_W-1:0]  res_char
);

    logic                         in_value_reg,  in_value_next;
    logic                         in_quote_reg,  in_quote_next;
    logic                         halted_reg,    halted_next;
    logic [kvst_pkg::COUNT_W-1:0] count_reg,     count_next;

    logic                         cur_value;
    logic                         cur_quote;
    logic                         cur_halted;
    logic [kvst_pkg::COUNT_W-1:0] cur_count;
    logic [kvst_pkg::COUNT_W-1:0] count_inc;
    logic [kvst_pkg::COUNT_W-1:0] limit;

    always_comb
    begin
        cur_value  = first ? 1'b0 : in_value_reg;
        cur_quote  = first ? 1'b0 : in_quote_reg;
        cur_halted = first ? 1'b0 : halted_reg;
        cur_count  = first ? '0 : count_reg;
        count_inc  = cur_count + 1'b1;
        limit      = cur_value ? VALUE_LIMIT : KEY_LIMIT;

        in_value_next = cur_value;
        in_quote_next = cur_quote;
        halted_next   = cur_halted;
        count_next    = cur_count;
        res_valid     = 1'b0;
        res_kind      = kvst_pkg::KIND_KEY;
        res_char      = '0;

        if (!cur_halted)
        begin
            if (byte_class.is_term)
            begin
                halted_next = 1'b1;
                res_valid   = 1'b1;
                res_kind    = kvst_pkg::KIND_FINAL;
            end
            else if (!byte_class.is_quote && !cur_quote && !cur_value &&
                     byte_class.is_equal)
            begin
                in_value_next = 1'b1;
                in_quote_next = 1'b0;
                count_next    = '0;
            end
            else if (!byte_class.is_quote && !cur_quote && byte_class.is_sep)
            begin
                in_value_next = 1'b0;
                in_quote_next = 1'b0;
                count_next    = '0;
                res_valid     = 1'b1;
                res_kind      = kvst_pkg::KIND_MORE;
            end
            else
            begin
                count_next = count_inc;
                if (count_inc == limit)
                begin
                    halted_next = 1'b1;
                    res_valid   = 1'b1;
                    res_kind    = kvst_pkg::KIND_ERROR;
                end
                else if (byte_class.is_quote)
                begin
                    in_quote_next = !cur_quote;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_kind  = cur_value ? kvst_pkg::KIND_VALUE : kvst_pkg::KIND_KEY;
                    res_char  = in_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_value_reg <= 1'b0;
            in_quote_reg <= 1'b0;
            halted_reg   <= 1'b0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            in_value_reg <= in_value_next;
            in_quote_reg <= in_quote_next;
            halted_reg   <= halted_next;
            count_reg    <= count_next;
        end
    end

endmodule

>>> bench/key_value_string_tokenizer_unit_test.sv
`timescale 1ns / 1ps

module key_value_string_tokenizer_unit_test;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_BYTES   = 390;
    localparam int SETTLE_CYCLES = 8;

    typedef logic [kvst_pkg::CHAR_W-1:0] char_t;

    typedef struct {
        kvst_pkg::kind_t kind;
        char_t           ch;
    } token_t;

    class kv_token_scoreboard;
        char_t                          equal_chars[3];
        char_t                          sep_chars[3];
        bit                             in_value;
        bit                             in_quote;
        logic [kvst_pkg::COUNT_W-1:0]   seg_count;
        bit                             halted;
        token_t                         pending_tokens[$];
        int                             failures;

        function new();
            equal_chars = '{kvst_pkg::EQUAL_A_RESET, 8'd0, 8'd0};
            sep_chars   = '{kvst_pkg::SEP_A_RESET, 8'd0, 8'd0};
            in_value    = 1'b0;
            in_quote    = 1'b0;
            seg_count   = '0;
            halted      = 1'b0;
            failures    = 0;
        endfunction

        function void configure(kvst_pkg::reg_index_t idx, char_t value);
            case (idx)
                kvst_pkg::REG_EQUAL_A: equal_chars[0] = value;
                kvst_pkg::REG_EQUAL_B: equal_chars[1] = value;
                kvst_pkg::REG_EQUAL_C: equal_chars[2] = value;
                kvst_pkg::REG_SEP_A:   sep_chars[0] = value;
                kvst_pkg::REG_SEP_B:   sep_chars[1] = value;
                kvst_pkg::REG_SEP_C:   sep_chars[2] = value;
                default: ;
            endcase
        endfunction

        function void push_token(kvst_pkg::kind_t kind, char_t ch);
            token_t t;
            t.kind = kind;
            t.ch = ch;
            pending_tokens.push_back(t);
        endfunction

        // Returns 1 when the byte was handled, 0 when the halted parser dropped it.
        function bit accept_byte(char_t b, bit first);
            logic [kvst_pkg::COUNT_W-1:0] limit;
            bit is_equal;
            bit is_sep;
            if (first)
            begin
                in_value  = 1'b0;
                in_quote  = 1'b0;
                seg_count = '0;
                halted    = 1'b0;
            end
            if (halted)
                return 1'b0;
            if (b == kvst_pkg::CHAR_NUL || b == kvst_pkg::CHAR_LF || b == kvst_pkg::CHAR_CR)
            begin
                halted = 1'b1;
                push_token(kvst_pkg::KIND_FINAL, 8'd0);
                return 1'b1;
            end
            if (b != kvst_pkg::CHAR_QUOTE && !in_quote)
            begin
                is_equal = !in_value && (b == equal_chars[0] || b == equal_chars[1] ||
                                         b == equal_chars[2]);
                is_sep = (b == sep_chars[0] || b == sep_chars[1] || b == sep_chars[2]);
                if (is_equal)
                begin
                    in_value  = 1'b1;
                    in_quote  = 1'b0;
                    seg_count = '0;
                    return 1'b1;
                end
                if (is_sep)
                begin
                    in_value  = 1'b0;
                    in_quote  = 1'b0;
                    seg_count = '0;
                    push_token(kvst_pkg::KIND_MORE, 8'd0);
                    return 1'b1;
                end
            end
            limit = in_value ? kvst_pkg::VALUE_LIMIT : kvst_pkg::KEY_LIMIT;
            seg_count = seg_count + 1'b1;
            if (seg_count == limit)
            begin
                halted = 1'b1;
                push_token(kvst_pkg::KIND_ERROR, 8'd0);
                return 1'b1;
            end
            if (b == kvst_pkg::CHAR_QUOTE)
            begin
                in_quote = !in_quote;
                return 1'b1;
            end
            push_token(in_value ? kvst_pkg::KIND_VALUE : kvst_pkg::KIND_KEY, b);
            return 1'b1;
        endfunction

        function void check_token(logic [2:0] kind, char_t ch);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d, out_char 0x%02h", kind, ch);
                failures++;
                return;
            end
            want = pending_tokens.pop_front();
            if (kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                failures++;
            end
            if (ch !== want.ch)
            begin
                $error("out_char: expected 0x%02h, got 0x%02h", want.ch, ch);
                failures++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    char_t                          s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    char_t                          m_axis_tdata;
    logic [2:0]                     m_axis_tuser;
    logic                           cfg_we = 1'b0;
    logic [kvst_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    char_t                          cfg_data = '0;

    kv_token_scoreboard sb = new();
    int  live_bytes = 0;
    int  sink_stall = 0;
    bit  calm = 1'b0;

    key_value_string_tokenizer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    always @(posedge clk)
    begin
        if (sink_stall != 0)
        begin
            m_axis_tready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            sink_stall <= idle_gap();
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tuser, m_axis_tdata);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL key_value_string_tokenizer_unit");
        $finish;
    end

    task automatic send_byte(char_t b, bit first);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        do @(posedge clk); while (!s_axis_tready);
        void'(sb.accept_byte(b, first));
        live_bytes++;
        gap = idle_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_register(kvst_pkg::reg_index_t idx, char_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.configure(idx, value);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic char_t pick_delim(bit equal);
        int start;
        char_t c;
        start = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            c = equal ? sb.equal_chars[(start + k) % 3] : sb.sep_chars[(start + k) % 3];
            if (c != 8'd0)
                return c;
        end
        return kvst_pkg::CHAR_NUL;
    endfunction

    function automatic char_t pick_char();
        int r;
        char_t c;
        r = $urandom_range(0, 99);
        if (r < 50)
            return char_t'(8'h61 + $urandom_range(0, 25));
        if (r < 60)
            return kvst_pkg::CHAR_QUOTE;
        if (r < 70)
            c = pick_delim(1'b1);
        else if (r < 80)
            c = pick_delim(1'b0);
        else if (r < 92)
            c = char_t'($urandom_range(1, 255));
        else
            c = char_t'(8'h30 + $urandom_range(0, 9));
        return (c == kvst_pkg::CHAR_NUL) ? 8'h7A : c;
    endfunction

    function automatic int segment_length();
        if ($urandom_range(0, 99) < 5)
            return $urandom_range(60, 68);
        return $urandom_range(0, 6);
    endfunction

    // Mostly well-formed strings with random content, some noise and broken strings.
    task automatic send_string();
        char_t text[$];
        int  pairs;
        int  len;
        int  r;
        int  term;
        bit  restart;
        r = $urandom_range(0, 99);
        restart = ($urandom_range(0, 9) != 0);
        calm <= ($urandom_range(0, 7) == 0);
        if (r < 10)
        begin
            len = $urandom_range(1, 12);
            repeat (len) text.push_back(char_t'($urandom_range(0, 255)));
            foreach (text[i])
                send_byte(text[i], $urandom_range(0, 3) == 0);
            return;
        end
        pairs = $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++)
        begin
            if (p != 0)
                text.push_back(pick_delim(1'b0));
            len = segment_length();
            repeat (len) text.push_back(pick_char());
            if ($urandom_range(0, 3) != 0)
            begin
                text.push_back(pick_delim(1'b1));
                len = segment_length();
                repeat (len) text.push_back(pick_char());
            end
        end
        if (r < 95)
        begin
            term = $urandom_range(0, 2);
            text.push_back(term == 0 ? kvst_pkg::CHAR_NUL :
                           (term == 1 ? kvst_pkg::CHAR_LF : kvst_pkg::CHAR_CR));
        end
        if (r >= 80 && r < 95)
        begin
            len = $urandom_range(1, 3);
            repeat (len) text.push_back(pick_char());
        end
        foreach (text[i])
            send_byte(text[i], i == 0 && restart);
    endtask

    task automatic load_settings(int phase);
        char_t vals[6];
        kvst_pkg::reg_index_t idx;
        case (phase)
            1: vals = '{8'h3D, 8'h3A, 8'hFF, 8'h3B, 8'h2C, 8'h20};
            2: vals = '{kvst_pkg::CHAR_QUOTE, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h26};
            3: vals = '{8'h3D, 8'h00, 8'h00, 8'h3D, 8'h3B, 8'h00};
            default:
                foreach (vals[i])
                    vals[i] = char_t'($urandom_range(0, 255));
        endcase
        idx = kvst_pkg::REG_EQUAL_A;
        foreach (vals[i])
        begin
            write_register(idx, vals[i]);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [8:0] directed[$];
        directed = '{
            {1'b1, 8'h61}, {1'b0, 8'h3D}, {1'b0, 8'h3D}, {1'b0, kvst_pkg::CHAR_QUOTE},
            {1'b0, 8'h3B}, {1'b0, kvst_pkg::CHAR_CR}, {1'b0, 8'h62}, {1'b1, 8'h3B},
            {1'b0, 8'h3D}, {1'b0, 8'h3B}, {1'b0, kvst_pkg::CHAR_QUOTE}, {1'b0, 8'h3D},
            {1'b0, kvst_pkg::CHAR_QUOTE}, {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, 8'h3D},
            {1'b0, 8'h7F}, {1'b0, kvst_pkg::CHAR_LF}, {1'b1, 8'h01},
            {1'b0, kvst_pkg::CHAR_NUL}, {1'b0, 8'h63}, {1'b1, 8'h78}, {1'b0, 8'h3B}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][8]);
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase != 0)
            begin
                wait_idle();
                load_settings(phase);
                @(posedge clk);
            end
            while (live_bytes < (phase + 1) * PHASE_BYTES)
                send_string();
        end
        wait_idle();
        if (sb.failures == 0)
            $display("PASS key_value_string_tokenizer_unit");
        else
            $display("FAIL key_value_string_tokenizer_unit");
        $finish;
    end

endmodule
